@@ hw/rtl/pgdc_pkg.sv @@
// Package for the proleptic Gregorian day/date converter.
// Holds field widths, calendar constants, the month length table and the
// operand/result structs of the shared step unit. Depends on nothing.
package pgdc_pkg;

  localparam int unsigned CountW  = 22;
  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayInW  = 8;
  localparam int unsigned DayOutW = 5;
  localparam int unsigned AccW    = 23;
  localparam int unsigned LenW    = 18;

  // Operation codes.
  localparam logic OpSplit = 1'b0;
  localparam logic OpBuild = 1'b1;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Group lengths in days and in years.
  localparam logic [LenW-1:0] CycleDays     = 18'd146097;
  localparam logic [LenW-1:0] CenturyLong   = 18'd36525;
  localparam logic [LenW-1:0] CenturyShort  = 18'd36524;
  localparam logic [LenW-1:0] QuadLong      = 18'd1461;
  localparam logic [LenW-1:0] QuadShort     = 18'd1460;
  localparam logic [LenW-1:0] YearLong      = 18'd366;
  localparam logic [LenW-1:0] YearShort     = 18'd365;
  localparam logic [LenW-1:0] CycleYears    = 18'd400;
  localparam logic [LenW-1:0] CenturyYears  = 18'd100;
  localparam logic [LenW-1:0] QuadYears     = 18'd4;
  localparam logic [LenW-1:0] OneYear       = 18'd1;

  localparam logic [MonthW-1:0] LastMonth = 4'd11;
  localparam logic [MonthW-1:0] Months    = 4'd12;

  localparam logic [DayOutW-1:0] MonthLen [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Length of zero-based month m; February gains a day in a leap year.
  function automatic logic [DayOutW-1:0] mon_len(logic [MonthW-1:0] m, logic lp);
    logic [DayOutW-1:0] n;
    n = (m < Months) ? MonthLen[m] : 5'd31;
    if (m == 4'd1 && lp) begin
      n = n + 5'd1;
    end
    return n;
  endfunction

  typedef struct packed {
    logic [CountW-1:0] a;
    logic [LenW-1:0]   b;
    logic [AccW-1:0]   c;
    logic [LenW-1:0]   d;
  } step_op_t;

  typedef struct packed {
    logic              ge;
    logic [CountW-1:0] diff;
    logic [AccW-1:0]   sum;
  } step_res_t;

endpackage

@@ hw/rtl/pgdc_if.sv @@
// Valid/ready channel interfaces for the converter's request and response.
// Depends on nothing; widths follow the fields of the converter package.
interface pgdc_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [21:0] day_count;
  logic [13:0] year_in;
  logic [3:0]  month_in;
  logic [7:0]  day_in;

  modport source (output valid, operation, day_count, year_in, month_in, day_in,
                  input ready);
  modport sink   (input valid, operation, day_count, year_in, month_in, day_in,
                  output ready);
endinterface

interface pgdc_rsp_if;
  logic        valid;
  logic        ready;
  logic [21:0] day_count_out;
  logic [13:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic        bad_input;

  modport source (output valid, day_count_out, year_out, month_out, day_out, bad_input,
                  input ready);
  modport sink   (input valid, day_count_out, year_out, month_out, day_out, bad_input,
                  output ready);
endinterface

@@ hw/rtl/pgdc_step_unit.sv @@
// Shared arithmetic unit of the converter: one compare-and-subtract and one add.
// Depends on pgdc_pkg for the operand and result structs.
module pgdc_step_unit (
  input  pgdc_pkg::step_op_t  op_i,
  output pgdc_pkg::step_res_t res_o
);

  logic [pgdc_pkg::CountW-1:0] b_ext;
  logic [pgdc_pkg::AccW-1:0]   d_ext;

  assign b_ext = {{(pgdc_pkg::CountW - pgdc_pkg::LenW){1'b0}}, op_i.b};
  assign d_ext = {{(pgdc_pkg::AccW - pgdc_pkg::LenW){1'b0}}, op_i.d};

  assign res_o.ge   = (op_i.a >= b_ext);
  assign res_o.diff = op_i.a - b_ext;
  assign res_o.sum  = op_i.c + d_ext;

endmodule

@@ hw/rtl/proleptic_gregorian_day_date_convert_top.sv @@
// Proleptic Gregorian day count <-> date converter, top level.
// A split walks the day count through 400-year cycles, centuries, 4-year groups,
// years and months; a build takes the same walk over the year, then adds the
// day. A build with a bad month goes from the transfer straight to the final
// state. One request at a time, set by the single shared subtract/add unit.
// Reset clears all state.
module proleptic_gregorian_day_date_convert_top #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  pgdc_req_if.sink   req_i,
  pgdc_rsp_if.source rsp_o
);

  typedef enum logic [2:0] {
    StIdle, StCycle, StCent, StQuad, StYear, StMon, StAdd, StFin
  } state_e;

  localparam logic [16:0] MaxYearW = 17'(MAX_YEAR);

  state_e                      state_q;
  logic                        op_q;
  logic                        bad_q;
  logic [pgdc_pkg::CountW-1:0] a_q;
  logic [pgdc_pkg::AccW-1:0]   c_q;
  logic [pgdc_pkg::CountW-1:0] echo_q;
  logic [pgdc_pkg::MonthW-1:0] month_q;
  logic [pgdc_pkg::MonthW-1:0] mon_q;
  logic [pgdc_pkg::DayInW-1:0] day_q;
  logic                        cent_nz_q;
  logic                        first_quad_q;
  logic [1:0]                  yiq_q;

  logic                         ov_q;
  logic [pgdc_pkg::CountW-1:0]  out_count_q;
  logic [pgdc_pkg::YearW-1:0]   out_year_q;
  logic [pgdc_pkg::MonthW-1:0]  out_month_q;
  logic [pgdc_pkg::DayOutW-1:0] out_day_q;
  logic                         out_bad_q;

  pgdc_pkg::step_op_t  unit_op;
  pgdc_pkg::step_res_t unit_res;

  logic                        leap_now;
  logic [pgdc_pkg::LenW-1:0]   len;
  logic [pgdc_pkg::LenW-1:0]   step;
  logic                        req_bad;
  logic [pgdc_pkg::YearW-1:0]  year_clamped;
  logic                        out_free;
  logic                        mon_go;
  logic [pgdc_pkg::AccW-1:0]   dec;
  logic [pgdc_pkg::CountW-1:0] total;

  // A year is leap when it opens a 4-year group, unless that group opens a
  // century other than the first of the 400-year cycle.
  assign leap_now = (yiq_q == 2'd0) && !(first_quad_q && cent_nz_q);

  assign req_bad = (req_i.month_in == 4'd0) || (req_i.month_in > pgdc_pkg::Months);
  assign year_clamped = ({3'd0, req_i.year_in} > MaxYearW) ? MaxYearW[13:0] : req_i.year_in;

  assign out_free = !ov_q || rsp_o.ready;

  always_comb begin
    len  = '0;
    step = '0;
    case (state_q)
      StCycle: begin
        len  = pgdc_pkg::CycleDays;
        step = pgdc_pkg::CycleYears;
      end
      StCent: begin
        len  = cent_nz_q ? pgdc_pkg::CenturyShort : pgdc_pkg::CenturyLong;
        step = pgdc_pkg::CenturyYears;
      end
      StQuad: begin
        len  = (first_quad_q && cent_nz_q) ? pgdc_pkg::QuadShort : pgdc_pkg::QuadLong;
        step = pgdc_pkg::QuadYears;
      end
      StYear: begin
        len  = leap_now ? pgdc_pkg::YearLong : pgdc_pkg::YearShort;
        step = pgdc_pkg::OneYear;
      end
      StMon:   len = {13'd0, pgdc_pkg::mon_len(mon_q, leap_now)};
      StAdd:   len = {10'd0, day_q};
      default: len = '0;
    endcase
  end

  // Splitting subtracts days and counts years; building subtracts years and
  // counts days.
  always_comb begin
    unit_op.a = a_q;
    unit_op.c = c_q;
    if (op_q == pgdc_pkg::OpSplit) begin
      unit_op.b = len;
      unit_op.d = step;
    end else begin
      unit_op.b = step;
      unit_op.d = len;
    end
  end

  pgdc_step_unit u_step (
    .op_i  (unit_op),
    .res_o (unit_res)
  );

  always_comb begin
    if (op_q == pgdc_pkg::OpSplit) begin
      mon_go = (mon_q != pgdc_pkg::LastMonth) && unit_res.ge;
    end else begin
      mon_go = ((mon_q + 4'd1) < month_q);
    end
  end

  assign dec   = c_q - 23'd1;
  assign total = (c_q == '0) ? '0 :
                 (dec > {1'b0, pgdc_pkg::CountMax}) ? pgdc_pkg::CountMax : dec[21:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      op_q         <= pgdc_pkg::OpSplit;
      bad_q        <= 1'b0;
      a_q          <= '0;
      c_q          <= '0;
      echo_q       <= '0;
      month_q      <= '0;
      mon_q        <= '0;
      day_q        <= '0;
      cent_nz_q    <= 1'b0;
      first_quad_q <= 1'b1;
      yiq_q        <= '0;
      ov_q         <= 1'b0;
      out_count_q  <= '0;
      out_year_q   <= '0;
      out_month_q  <= '0;
      out_day_q    <= '0;
      out_bad_q    <= 1'b0;
    end else begin
      // The final state loads the next result itself when the output frees up.
      if (ov_q && rsp_o.ready && (state_q != StFin)) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (req_i.valid) begin
            op_q         <= req_i.operation;
            echo_q       <= req_i.day_count;
            month_q      <= req_i.month_in;
            day_q        <= req_i.day_in;
            mon_q        <= '0;
            c_q          <= '0;
            cent_nz_q    <= 1'b0;
            first_quad_q <= 1'b1;
            yiq_q        <= '0;
            if (req_i.operation == pgdc_pkg::OpSplit) begin
              a_q     <= req_i.day_count;
              bad_q   <= 1'b0;
              state_q <= StCycle;
            end else begin
              a_q     <= {8'd0, year_clamped};
              bad_q   <= req_bad;
              state_q <= req_bad ? StFin : StCycle;
            end
          end
        end
        StCycle: begin
          if (unit_res.ge) begin
            a_q <= unit_res.diff;
            c_q <= unit_res.sum;
          end else begin
            state_q <= StCent;
          end
        end
        StCent: begin
          if (unit_res.ge) begin
            a_q       <= unit_res.diff;
            c_q       <= unit_res.sum;
            cent_nz_q <= 1'b1;
          end else begin
            state_q <= StQuad;
          end
        end
        StQuad: begin
          if (unit_res.ge) begin
            a_q          <= unit_res.diff;
            c_q          <= unit_res.sum;
            first_quad_q <= 1'b0;
          end else begin
            state_q <= StYear;
          end
        end
        StYear: begin
          if (unit_res.ge) begin
            a_q   <= unit_res.diff;
            c_q   <= unit_res.sum;
            yiq_q <= yiq_q + 2'd1;
          end else begin
            state_q <= StMon;
          end
        end
        StMon: begin
          if (mon_go) begin
            mon_q <= mon_q + 4'd1;
            if (op_q == pgdc_pkg::OpSplit) begin
              a_q <= unit_res.diff;
            end else begin
              c_q <= unit_res.sum;
            end
          end else begin
            state_q <= (op_q == pgdc_pkg::OpSplit) ? StFin : StAdd;
          end
        end
        StAdd: begin
          c_q     <= unit_res.sum;
          state_q <= StFin;
        end
        StFin: begin
          if (out_free) begin
            ov_q    <= 1'b1;
            state_q <= StIdle;
            if (op_q == pgdc_pkg::OpSplit) begin
              out_count_q <= echo_q;
              out_year_q  <= c_q[13:0];
              out_month_q <= mon_q + 4'd1;
              out_day_q   <= a_q[4:0] + 5'd1;
              out_bad_q   <= 1'b0;
            end else begin
              out_count_q <= bad_q ? '0 : total;
              out_year_q  <= '0;
              out_month_q <= '0;
              out_day_q   <= '0;
              out_bad_q   <= bad_q;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign req_i.ready         = (state_q == StIdle);
  assign rsp_o.valid         = ov_q;
  assign rsp_o.day_count_out = out_count_q;
  assign rsp_o.year_out      = out_year_q;
  assign rsp_o.month_out     = out_month_q;
  assign rsp_o.day_out       = out_day_q;
  assign rsp_o.bad_input     = out_bad_q;

  // Four years in a 4-year group can never all fit under the remainder.
  a_year_in_quad : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StYear && unit_res.ge) |-> (yiq_q != 2'd3))
    else $error("year walk ran past a 4-year group");

  // After the month walk the split remainder is a day within the month.
  a_day_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin && op_q == pgdc_pkg::OpSplit) |-> (a_q < 22'd31))
    else $error("split remainder does not fit a month");

  // A build with a bad month skips the walk entirely.
  a_bad_skip : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_i.operation == pgdc_pkg::OpBuild && req_bad)
    |=> (state_q == StFin && bad_q))
    else $error("bad month did not go straight to the result");

  // The split month counter never passes December.
  a_month_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMon && op_q == pgdc_pkg::OpSplit) |-> (mon_q <= pgdc_pkg::LastMonth))
    else $error("split month counter out of range");

endmodule

@@ verif/proleptic_gregorian_day_date_convert_top_tb.sv @@
// Self-checking testbench for the proleptic Gregorian day/date converter.
// Uses pgdc_pkg and the request/response interfaces from pgdc_if.sv; a built-in
// calendar predictor checks every response against the request that caused it.
module proleptic_gregorian_day_date_convert_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxYear     = 9999;
  localparam int unsigned DaysPer400  = 146097;
  localparam int unsigned RandomItems = 1100;
  localparam int unsigned DrainCycles = 120;
  localparam int unsigned HoldCycles  = 600;
  localparam int unsigned CycleLimit  = 1000000;

  typedef struct packed {
    logic                        op;
    logic [pgdc_pkg::CountW-1:0] count;
    logic [pgdc_pkg::YearW-1:0]  year;
    logic [pgdc_pkg::MonthW-1:0] month;
    logic [pgdc_pkg::DayInW-1:0] day;
  } conv_req_t;

  typedef struct packed {
    logic [pgdc_pkg::CountW-1:0]  count;
    logic [pgdc_pkg::YearW-1:0]   year;
    logic [pgdc_pkg::MonthW-1:0]  month;
    logic [pgdc_pkg::DayOutW-1:0] day;
    logic                         bad;
  } conv_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pgdc_req_if req_if();
  pgdc_rsp_if rsp_if();

  proleptic_gregorian_day_date_convert_top #(
    .MAX_YEAR(MaxYear)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  conv_req_t   pending_requests[$];
  conv_res_t   awaited_results[$];
  conv_req_t   offered_req;
  int unsigned requests_sent;
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned hold_left;
  int unsigned holds_started;
  int unsigned cycles = 0;
  int unsigned error_count = 0;

  // A stretch in the middle of the run drops the random request gaps and response stalls; a receiver hold still wins.
  wire no_idle = (requests_sent >= 400) && (requests_sent < 520);

  // ---------------------------------------------------------------- calendar
  function automatic bit is_leap(longint unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic longint unsigned year_days(longint unsigned y);
    return is_leap(y) ? 366 : 365;
  endfunction

  function automatic int unsigned month_days(int unsigned m0, bit lp);
    case (m0)
      1:           return lp ? 29 : 28;
      3, 5, 8, 10: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic longint unsigned days_before(longint unsigned y);
    return y * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  function automatic conv_res_t calendar_convert(conv_req_t rq);
    conv_res_t       res;
    longint unsigned y;
    longint unsigned r;
    longint unsigned total;
    int unsigned     m;
    bit              lp;
    res = '0;
    if (rq.op == pgdc_pkg::OpSplit) begin
      y = (rq.count / DaysPer400) * 400;
      r = rq.count % DaysPer400;
      while (r >= year_days(y)) begin
        r -= year_days(y);
        y++;
      end
      lp = is_leap(y);
      m = 0;
      while (m < 11 && r >= month_days(m, lp)) begin
        r -= month_days(m, lp);
        m++;
      end
      res.count = rq.count;
      res.year  = y[pgdc_pkg::YearW-1:0];
      res.month = pgdc_pkg::MonthW'(m + 1);
      res.day   = pgdc_pkg::DayOutW'(r + 1);
    end else if (rq.month == 0 || rq.month > pgdc_pkg::Months) begin
      res.bad = 1'b1;
    end else begin
      y = (rq.year > MaxYear) ? MaxYear : rq.year;
      lp = is_leap(y);
      total = days_before(y);
      for (m = 1; m < rq.month; m++) begin
        total += month_days(m - 1, lp);
      end
      total += rq.day;
      // Day zero of January in year 0 cannot go below the first day.
      if (total != 0) begin
        total--;
      end
      if (total > pgdc_pkg::CountMax) begin
        total = pgdc_pkg::CountMax;
      end
      res.count = total[pgdc_pkg::CountW-1:0];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus
  task automatic add_split(longint unsigned d);
    conv_req_t rq;
    rq = '0;
    rq.op = pgdc_pkg::OpSplit;
    rq.count = (d > pgdc_pkg::CountMax) ? pgdc_pkg::CountMax : d[pgdc_pkg::CountW-1:0];
    rq.year = pgdc_pkg::YearW'($urandom());
    rq.month = pgdc_pkg::MonthW'($urandom());
    rq.day = pgdc_pkg::DayInW'($urandom());
    pending_requests.push_back(rq);
  endtask

  task automatic add_build(int unsigned y, int unsigned m, int unsigned dd);
    conv_req_t rq;
    rq = '0;
    rq.op = pgdc_pkg::OpBuild;
    rq.count = pgdc_pkg::CountW'($urandom());
    rq.year = pgdc_pkg::YearW'(y);
    rq.month = pgdc_pkg::MonthW'(m);
    rq.day = pgdc_pkg::DayInW'(dd);
    pending_requests.push_back(rq);
  endtask

  task automatic add_random_split();
    longint unsigned y;
    longint unsigned k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: add_split($urandom_range(0, pgdc_pkg::CountMax));
      4, 5:       add_split($urandom_range(0, 2 * DaysPer400));
      6: begin
        y = $urandom_range(0, 11400);
        add_split(days_before(y) + $urandom_range(0, 61));
      end
      7: begin
        y = $urandom_range(0, 11400);
        add_split(days_before(y + 1) - 1 - $urandom_range(0, 1));
      end
      8: begin
        k = $urandom_range(0, 27);
        if ($urandom_range(0, 1) == 0) begin
          add_split(k * DaysPer400 + $urandom_range(0, 3));
        end else begin
          add_split((k + 1) * DaysPer400 - 1 - $urandom_range(0, 2));
        end
      end
      default: add_split(pgdc_pkg::CountMax - $urandom_range(0, 800));
    endcase
  endtask

  task automatic add_random_build();
    int unsigned special_years[14] = '{0, 4, 100, 200, 300, 399, 400, 1600, 1700,
                                       1900, 2000, 2100, 9996, 9999};
    int unsigned y;
    int unsigned m;
    int unsigned dd;
    case ($urandom_range(0, 19))
      14, 15:  y = special_years[$urandom_range(0, 13)];
      16, 17:  y = $urandom_range(MaxYear + 1, 16383);
      18, 19:  y = $urandom_range(0, 450);
      default: y = $urandom_range(0, MaxYear);
    endcase
    m = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
    case ($urandom_range(0, 9))
      6, 7: dd = $urandom_range(0, 255);
      8: begin
        dd = $urandom_range(28, 32);
        if (dd == 32) begin
          dd = 0;
        end
      end
      9:       dd = 255 - $urandom_range(0, 3);
      default: dd = $urandom_range(1, 31);
    endcase
    add_build(y, m, dd);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) begin
      return 0;
    end
    if (p < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------- request driver
  always @(posedge clk_i or negedge rst_ni) begin
    logic offer;
    if (!rst_ni) begin
      req_if.valid     <= 1'b0;
      req_if.operation <= pgdc_pkg::OpSplit;
      req_if.day_count <= '0;
      req_if.year_in   <= '0;
      req_if.month_in  <= '0;
      req_if.day_in    <= '0;
      offered_req      <= '0;
      send_gap         <= 0;
      requests_sent    <= 0;
    end else begin
      offer = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        awaited_results.push_back(calendar_convert(offered_req));
        requests_sent <= requests_sent + 1;
        offer = 1'b0;
      end
      if (!offer) begin
        if (send_gap != 0 && !no_idle) begin
          send_gap <= send_gap - 1;
        end else if (pending_requests.size() != 0) begin
          offered_req      <= pending_requests[0];
          req_if.operation <= pending_requests[0].op;
          req_if.day_count <= pending_requests[0].count;
          req_if.year_in   <= pending_requests[0].year;
          req_if.month_in  <= pending_requests[0].month;
          req_if.day_in    <= pending_requests[0].day;
          void'(pending_requests.pop_front());
          send_gap <= pick_gap();
          offer = 1'b1;
        end
      end
      req_if.valid <= offer;
    end
  end

  // ---------------------------------------------------------------- response monitor
  task automatic note_error(string what, conv_res_t want, conv_res_t got);
    error_count++;
    if (error_count <= 10) begin
      $display("%s: expected count=%0d year=%0d month=%0d day=%0d bad=%0d", what,
               want.count, want.year, want.month, want.day, want.bad);
      $display("  got count=%0d year=%0d month=%0d day=%0d bad=%0d",
               got.count, got.year, got.month, got.day, got.bad);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    conv_res_t got;
    conv_res_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.count = rsp_if.day_count_out;
        got.year  = rsp_if.year_out;
        got.month = rsp_if.month_out;
        got.day   = rsp_if.day_out;
        got.bad   = rsp_if.bad_input;
        if (awaited_results.size() == 0) begin
          note_error("Response with no request outstanding", '0, got);
        end else begin
          want = awaited_results.pop_front();
          if (got.count !== want.count || got.year !== want.year ||
              got.month !== want.month || got.day !== want.day ||
              got.bad !== want.bad) begin
            note_error("Response mismatch", want, got);
          end
        end
      end
      if (hold_left != 0) begin
        rsp_if.ready <= 1'b0;
      end else if (no_idle) begin
        rsp_if.ready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left   <= stall_left - 1;
        rsp_if.ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left   <= pick_gap();
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Twice in the run the receiver refuses transfers for a long stretch while
  // requests keep coming, so that the converter backs up onto its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left     <= 0;
      holds_started <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_started < 2 && requests_sent >= 200 * (holds_started + 1)) begin
      hold_left     <= HoldCycles;
      holds_started <= holds_started + 1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    // Cycle and century edges, the leap day and the very ends of the count.
    add_split(0);
    add_split(59);
    add_split(60);
    add_split(365);
    add_split(366);
    add_split(36524);
    add_split(36525);
    add_split(DaysPer400 - 1);
    add_split(DaysPer400);
    add_split(pgdc_pkg::CountMax);
    add_split(days_before(1900) + 58);
    add_split(days_before(2000) + 59);
    // Day zero, leap rules, carry past month end, clamped years, bad months.
    add_build(0, 1, 0);
    add_build(0, 1, 1);
    add_build(2000, 2, 29);
    add_build(1900, 2, 29);
    add_build(1900, 3, 0);
    add_build(9999, 12, 255);
    add_build(16383, 12, 31);
    add_build(10000, 1, 1);
    add_build(5, 0, 1);
    add_build(5, 13, 1);
    add_build(5, 15, 31);
    add_build(399, 12, 31);
    add_build(2024, 7, 200);

    for (int unsigned i = 0; i < RandomItems; i++) begin
      if ($urandom_range(0, 1) == 0) begin
        add_random_split();
      end else begin
        add_random_build();
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0 || req_if.valid || awaited_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
